>>> rtl/lzse_pkg.sv
// Shared types and constants for the LZ sequence token encoder.
package lzse_pkg;

  localparam int unsigned BLOCK_BYTES = 8192;
  localparam int unsigned LEN_W       = 14;
  localparam int unsigned OFF_W       = 16;

  localparam logic [LEN_W-1:0] LEN_NIB_MAX   = LEN_W'(15);
  localparam logic [LEN_W-1:0] LEN_EXT_RUN   = LEN_W'(255);
  localparam logic [LEN_W-1:0] LEN_MIN_MATCH = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_BLOCK     = LEN_W'(BLOCK_BYTES);
  // Shortest match whose token nibble saturates.
  localparam logic [LEN_W-1:0] LEN_MATCH_SAT = LEN_W'(18);

  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_LITERAL = 1'b1;

  typedef struct packed {
    logic             command;
    logic [LEN_W-1:0] literal_count;
    logic [LEN_W-1:0] match_length;
    logic [OFF_W-1:0] match_offset;
    logic [7:0]       literal_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  // One classified item, as the back end expands it into bytes.
  typedef struct packed {
    logic             err;
    logic [7:0]       first_byte;
    logic             lit_ext;
    logic [LEN_W-1:0] lit_ext_len;
    logic             tail;
    logic [OFF_W-1:0] offset;
    logic             match_ext;
    logic [LEN_W-1:0] match_ext_len;
  } job_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LIT_EXT,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCH_EXT
  } phase_e;

endpackage

>>> rtl/lzse_front.sv
// Front end: checks item order, tracks the open sequence and builds jobs.
module lzse_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  lzse_pkg::in_item_t item_i,
  output lzse_pkg::job_t   job_o
);
  import lzse_pkg::*;

  logic [LEN_W-1:0] lit_left_q, lit_left_d;
  logic [LEN_W-1:0] pend_ml_q, pend_ml_d;
  logic [OFF_W-1:0] pend_off_q, pend_off_d;

  logic [LEN_W-1:0] lit, ml;
  logic [3:0]       lc, mc;
  logic             hdr_bad;
  logic [LEN_W-1:0] tail_ml;
  logic [OFF_W-1:0] tail_off;

  always_comb begin
    lit = item_i.literal_count;
    ml  = item_i.match_length;
    hdr_bad = (lit_left_q != '0) || (ml == LEN_W'(1)) || (ml == LEN_W'(2)) ||
              (lit > LEN_BLOCK) || (ml > LEN_BLOCK);
    lc = (lit >= LEN_NIB_MAX) ? 4'hF : lit[3:0];
    if (ml == '0) begin
      mc = 4'h0;
    end else if (ml >= LEN_MATCH_SAT) begin
      mc = 4'hF;
    end else begin
      mc = 4'((ml - LEN_MIN_MATCH));
    end

    lit_left_d = lit_left_q;
    pend_ml_d  = pend_ml_q;
    pend_off_d = pend_off_q;
    tail_ml    = pend_ml_q;
    tail_off   = pend_off_q;

    job_o = '0;
    if (item_i.command == CMD_HEADER) begin
      if (hdr_bad) begin
        job_o.err = 1'b1;
      end else begin
        job_o.first_byte  = {lc, mc};
        job_o.lit_ext     = (lit >= LEN_NIB_MAX);
        job_o.lit_ext_len = lit - LEN_NIB_MAX;
        tail_ml           = ml;
        tail_off          = item_i.match_offset;
        job_o.tail        = (lit == '0) && (ml != '0);
        lit_left_d        = lit;
        if (lit == '0) begin
          pend_ml_d  = '0;
          pend_off_d = '0;
        end else begin
          pend_ml_d  = ml;
          pend_off_d = (ml != '0) ? item_i.match_offset : '0;
        end
      end
    end else begin
      if (lit_left_q == '0) begin
        job_o.err = 1'b1;
      end else begin
        job_o.first_byte = item_i.literal_byte;
        lit_left_d       = lit_left_q - LEN_W'(1);
        job_o.tail       = (lit_left_q == LEN_W'(1)) && (pend_ml_q != '0);
        if (lit_left_q == LEN_W'(1)) begin
          pend_ml_d  = '0;
          pend_off_d = '0;
        end
      end
    end
    job_o.offset        = tail_off;
    job_o.match_ext     = (tail_ml >= LEN_MATCH_SAT);
    job_o.match_ext_len = tail_ml - LEN_MATCH_SAT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_left_q <= '0;
      pend_ml_q  <= '0;
      pend_off_q <= '0;
    end else if (accept_i) begin
      lit_left_q <= lit_left_d;
      pend_ml_q  <= pend_ml_d;
      pend_off_q <= pend_off_d;
    end
  end

endmodule

>>> rtl/lzse_fifo.sv
// Two-entry job queue between the front and back ends.
module lzse_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzse_pkg::job_t push_job_i,
  input  logic           pop_i,
  output lzse_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import lzse_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

>>> rtl/lzse_back.sv
// Back end: expands a job into registered output bytes, one per cycle unless stalled.
module lzse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lzse_pkg::job_t    job_i,
  input  logic              job_valid_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lzse_pkg::out_item_t out_item_o
);
  import lzse_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  out_item_t        out_q, out_d;
  logic             out_vld_q, out_vld_d;
  logic             load, go;
  logic             run_done;
  logic [7:0]       run_byte;

  assign load = !out_vld_q || !out_stall_i;
  assign go   = load && job_valid_i;

  // One step of an extension run: 255 while it fits, then the remainder.
  assign run_done = (cnt_q < LEN_EXT_RUN);
  assign run_byte = run_done ? cnt_q[7:0] : 8'hFF;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    pop_o     = 1'b0;
    if (load) begin
      out_vld_d = go;
    end
    if (go) begin
      out_d = '0;
      case (phase_q)
        PH_FIRST: begin
          out_d.out_byte = job_i.err ? 8'h00 : job_i.first_byte;
          out_d.error    = job_i.err;
          out_d.last     = job_i.err || (!job_i.lit_ext && !job_i.tail);
          if (job_i.err) begin
            pop_o = 1'b1;
          end else if (job_i.lit_ext) begin
            phase_d = PH_LIT_EXT;
            cnt_d   = job_i.lit_ext_len;
          end else if (job_i.tail) begin
            phase_d = PH_OFF_LO;
          end else begin
            pop_o = 1'b1;
          end
        end
        PH_LIT_EXT: begin
          out_d.out_byte = run_byte;
          out_d.last     = run_done && !job_i.tail;
          if (!run_done) begin
            cnt_d = cnt_q - LEN_EXT_RUN;
          end else if (job_i.tail) begin
            phase_d = PH_OFF_LO;
          end else begin
            phase_d = PH_FIRST;
            pop_o   = 1'b1;
          end
        end
        PH_OFF_LO: begin
          out_d.out_byte = job_i.offset[7:0];
          phase_d        = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          out_d.out_byte = job_i.offset[15:8];
          out_d.last     = !job_i.match_ext;
          if (job_i.match_ext) begin
            phase_d = PH_MATCH_EXT;
            cnt_d   = job_i.match_ext_len;
          end else begin
            phase_d = PH_FIRST;
            pop_o   = 1'b1;
          end
        end
        PH_MATCH_EXT: begin
          out_d.out_byte = run_byte;
          out_d.last     = run_done;
          if (!run_done) begin
            cnt_d = cnt_q - LEN_EXT_RUN;
          end else begin
            phase_d = PH_FIRST;
            pop_o   = 1'b1;
          end
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/lz_sequence_token_encoder_top.sv
// Top level of the LZ sequence token encoder: front end, job queue, back end.
//
//   channel   direction   handshake                payload
//   in        sink        in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out       source      out_valid_o / out_stall_i out_item_o (out_item_t)
//
// The back end expands each job into output beats: one for a literal or dropped
// item, one plus any literal run for a header, and a sequence with a match closes
// with 2 offset beats and any match run (a run of n is floor(n/255) + 1 beats).
// The front end takes one item per cycle until the two-entry job queue fills.
// Reset clears the open-sequence state, the queue and the output valid.
// A stalled output holds its beat; the queue holds two jobs, the one in progress too.
module lz_sequence_token_encoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzse_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lzse_pkg::out_item_t out_item_o
);
  import lzse_pkg::*;

  job_t front_job, head_job;
  logic accept, pop, q_empty, q_full;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  lzse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .job_o    (front_job)
  );

  lzse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (front_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  lzse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error |-> out_item_o.last)
    else $error("error beat without last");

  a_err_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error |-> (out_item_o.out_byte == 8'h00))
    else $error("error beat carries data");

  a_accept_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !q_empty)
    else $error("accepted item missing from job queue");

  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("job queue popped while empty");

endmodule

>>> test/lz_sequence_token_encoder_top_test.sv
// Self-checking testbench for the LZ sequence token encoder top level.
module lz_sequence_token_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lzse_pkg::*;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  lz_sequence_token_encoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  in_item_t   pending_items[$];
  out_item_t  expected_bytes[$];
  logic [7:0] seq_bytes[$];

  idle_mode_e  idle_mode   = IDLE_NONE;
  logic        in_taken    = 1'b0;
  logic        hold_rx     = 1'b0;
  int unsigned queued_cnt  = 0;
  int unsigned taken_cnt   = 0;
  int unsigned err_cnt     = 0;
  out_item_t   wanted_beat;

  // Shadow of the encoder's open-sequence state.
  logic [LEN_W-1:0] lits_left = '0;
  logic [LEN_W-1:0] pend_len  = '0;
  logic [OFF_W-1:0] pend_off  = '0;

  function automatic void add_run(input int unsigned len);
    int unsigned rest;
    rest = len;
    while (rest >= int'(LEN_EXT_RUN)) begin
      seq_bytes.push_back(8'hFF);
      rest -= int'(LEN_EXT_RUN);
    end
    seq_bytes.push_back(8'(rest));
  endfunction

  function automatic void add_match_tail();
    if (pend_len != '0) begin
      seq_bytes.push_back(pend_off[7:0]);
      seq_bytes.push_back(pend_off[15:8]);
      if (pend_len >= LEN_MATCH_SAT) add_run(int'(pend_len - LEN_MATCH_SAT));
      pend_len = '0;
      pend_off = '0;
    end
  endfunction

  function automatic void encode_item(input in_item_t it);
    int unsigned lc;
    int unsigned mc;
    bit          dropped;
    out_item_t   o;
    dropped = 1'b0;
    seq_bytes.delete();
    if (it.command == CMD_HEADER) begin
      if (lits_left != '0 || it.match_length == LEN_W'(1) || it.match_length == LEN_W'(2) ||
          it.literal_count > LEN_BLOCK || it.match_length > LEN_BLOCK) begin
        dropped = 1'b1;
      end else begin
        lc = (it.literal_count < LEN_NIB_MAX) ? int'(it.literal_count) : int'(LEN_NIB_MAX);
        if (it.match_length == '0) begin
          mc = 0;
        end else if (it.match_length < LEN_MATCH_SAT) begin
          mc = int'(it.match_length - LEN_MIN_MATCH);
        end else begin
          mc = int'(LEN_NIB_MAX);
        end
        seq_bytes.push_back(8'((lc << 4) | mc));
        if (lc == int'(LEN_NIB_MAX)) add_run(int'(it.literal_count - LEN_NIB_MAX));
        lits_left = it.literal_count;
        pend_len  = it.match_length;
        pend_off  = (it.match_length != '0) ? it.match_offset : '0;
        if (lits_left == '0) add_match_tail();
      end
    end else if (lits_left == '0) begin
      dropped = 1'b1;
    end else begin
      seq_bytes.push_back(it.literal_byte);
      lits_left = lits_left - 1'b1;
      if (lits_left == '0) add_match_tail();
    end
    if (dropped) begin
      o.out_byte = 8'h00;
      o.last     = 1'b1;
      o.error    = 1'b1;
      expected_bytes.push_back(o);
    end else begin
      foreach (seq_bytes[i]) begin
        o.out_byte = seq_bytes[i];
        o.last     = (i == seq_bytes.size() - 1);
        o.error    = 1'b0;
        expected_bytes.push_back(o);
      end
    end
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 85;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 26;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(99) < 85;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 26;
    return 1'b0;
  endfunction

  // Input side: advance to the next beat only once the current one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_items.size() != 0 && !sender_idles()) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= hold_rx || receiver_stalls();
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        encode_item(in_item_i);
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected beat: byte %h last %b error %b",
                               out_item_o.out_byte, out_item_o.last, out_item_o.error));
        end else begin
          wanted_beat = expected_bytes.pop_front();
          if (out_item_o.out_byte !== wanted_beat.out_byte ||
              out_item_o.last !== wanted_beat.last ||
              out_item_o.error !== wanted_beat.error) begin
            note_error($sformatf("beat mismatch: expected byte %h last %b error %b, got %h %b %b",
                                 wanted_beat.out_byte, wanted_beat.last, wanted_beat.error,
                                 out_item_o.out_byte, out_item_o.last, out_item_o.error));
          end
        end
      end
    end
  end

  function automatic in_item_t header_item(input int unsigned lit, input int unsigned ml,
                                           input int unsigned off);
    in_item_t it;
    it.command       = CMD_HEADER;
    it.literal_count = LEN_W'(lit);
    it.match_length  = LEN_W'(ml);
    it.match_offset  = OFF_W'(off);
    it.literal_byte  = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t literal_item(input logic [7:0] b);
    in_item_t it;
    it.command       = CMD_LITERAL;
    it.literal_count = LEN_W'($urandom);
    it.match_length  = LEN_W'($urandom);
    it.match_offset  = OFF_W'($urandom);
    it.literal_byte  = b;
    return it;
  endfunction

  function automatic void queue_item(input in_item_t it);
    pending_items.push_back(it);
    queued_cnt++;
  endfunction

  function automatic int unsigned pick_lit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(4);
    if (r < 85) return $urandom_range(18, 5);
    if (r < 97) return $urandom_range(40, 19);
    return $urandom_range(290, 250);
  endfunction

  function automatic int unsigned pick_match();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 65) return $urandom_range(20, 3);
    if (r < 90) return $urandom_range(300, 21);
    return $urandom_range(BLOCK_BYTES, 8000);
  endfunction

  // Queue a whole sequence; cut drops that many literals from its end.
  function automatic int unsigned queue_sequence(input int unsigned lit, input int unsigned ml,
                                                 input int unsigned cut);
    int unsigned made;
    queue_item(header_item(lit, ml, $urandom_range(65535)));
    made = 1;
    for (int unsigned k = 0; k + cut < lit; k++) begin
      // stray header inside the literal run
      if ($urandom_range(99) < 2) begin
        queue_item(header_item($urandom_range(40), pick_match(), $urandom));
        made++;
      end
      queue_item(literal_item(8'($urandom)));
      made++;
    end
    return made;
  endfunction

  task automatic drain();
    while (taken_cnt != queued_cnt || expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input idle_mode_e mode, input int unsigned target);
    int unsigned made;
    int unsigned r;
    int unsigned lit;
    idle_mode = mode;
    made = 0;
    while (made < target) begin
      r = $urandom_range(99);
      if (r < 85) begin
        made += queue_sequence(pick_lit(), pick_match(), 0);
      end else if (r < 90) begin
        queue_item(literal_item(8'($urandom)));
        made++;
      end else if (r < 94) begin
        queue_item(header_item($urandom_range(20), $urandom_range(2, 1), $urandom));
        made++;
      end else if (r < 97) begin
        if ($urandom_range(1) == 1) begin
          queue_item(header_item($urandom_range(16383, BLOCK_BYTES + 1), pick_match(), $urandom));
        end else begin
          queue_item(header_item(pick_lit(), $urandom_range(16383, BLOCK_BYTES + 1), $urandom));
        end
        made++;
      end else begin
        lit = $urandom_range(10, 3);
        made += queue_sequence(lit, pick_match(), $urandom_range(lit - 1, 1));
      end
    end
    drain();
  endtask

  // Back-pressure the output long enough for the job queue to fill.
  initial begin
    wait (taken_cnt >= 40);
    @(negedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(negedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("lz_sequence_token_encoder_top_test: errors");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no match, offset ignored
    queue_item(header_item(0, 0, 16'hFFFF));
    // shortest match with a zero offset
    queue_item(header_item(0, 3, 0));
    // longest match: full extension run
    queue_item(header_item(0, BLOCK_BYTES, 16'hA55A));
    // match nibble just saturated with a zero extension remainder, then one below saturation
    queue_item(header_item(0, 18, 16'h1234));
    queue_item(header_item(0, 17, 16'h00FF));
    // match lengths one and two
    queue_item(header_item(0, 1, 16'h0001));
    queue_item(header_item(0, 2, 16'h0002));
    // sizes above the block
    queue_item(header_item(BLOCK_BYTES + 1, 4, 16'h0003));
    queue_item(header_item(0, BLOCK_BYTES + 1, 16'h0004));
    queue_item(header_item(16383, 16383, 16'hFFFF));
    // literal while none is open
    queue_item(literal_item(8'hA5));
    // header while literals are open, then finish the sequence
    queue_item(header_item(2, 4, 16'hBEEF));
    queue_item(header_item(0, 0, 16'h0000));
    queue_item(literal_item(8'h00));
    queue_item(literal_item(8'hFF));
    // literals without a match
    queue_item(header_item(1, 0, 16'h0005));
    queue_item(literal_item(8'h5A));
    drain();

    // literal run of exactly one 255 beat and a zero remainder, streamed without idling
    void'(queue_sequence(270, 18, 0));
    run_phase(IDLE_NONE, 50);
    run_phase(IDLE_SENDER, 50);
    run_phase(IDLE_RECEIVER, 50);
    run_phase(IDLE_BOTH, 50);
    idle_mode = IDLE_NONE;
    drain();
    repeat (30) @(posedge clk_i);

    if (err_cnt == 0 && expected_bytes.size() == 0) begin
      $display("lz_sequence_token_encoder_top_test: clean");
    end else begin
      $display("lz_sequence_token_encoder_top_test: errors");
    end
    $finish;
  end

endmodule
